[sv/lr_pkg.sv]
// shared types and constants for the line rasterizer
// used by lr_front, lr_queue, lr_back and line_rasterizer; no dependencies
package lr_pkg;

   localparam int COORD_WIDTH = 11;
   localparam int COLOR_WIDTH = 16;
   localparam int ACC_WIDTH   = COORD_WIDTH + 1;   // error sums and pixel count
   localparam int REQ_DATA_W  = ((4 * COORD_WIDTH + COLOR_WIDTH + 7) / 8) * 8;
   localparam int RSP_DATA_W  = ((2 * COORD_WIDTH + COLOR_WIDTH + 7) / 8) * 8;
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = 1;
   localparam int QUEUE_CNT_W = 2;

   typedef logic [COORD_WIDTH-1:0] coord_type;
   typedef logic [COLOR_WIDTH-1:0] color_type;
   typedef logic [ACC_WIDTH-1:0]   acc_type;

   typedef enum logic {
      ACT_LOAD = 1'b0,
      ACT_STEP = 1'b1
   } action_type;

   typedef enum logic [1:0] {
      DIR_NONE  = 2'd0,
      DIR_PLUS  = 2'd1,
      DIR_MINUS = 2'd3
   } dir_type;

   // one classified item on its way from front to back
   typedef struct packed {
      action_type action;
      coord_type  col;
      coord_type  row;
      coord_type  abs_dx;
      coord_type  abs_dy;
      dir_type    step_col;
      dir_type    step_row;
      coord_type  major_len;
      color_type  color;
   } entry_type;

   // result beat payload
   typedef struct packed {
      logic      last;
      coord_type x;
      coord_type y;
      color_type color;
   } pixel_type;

endpackage

[sv/lr_front.sv]
// front end: classifies an input beat and works out the line setup on loads
// depends on lr_pkg
module lr_front (
   input  logic              req_valid,
   output logic              req_ready,
   input  lr_pkg::action_type action,
   input  lr_pkg::coord_type start_x,
   input  lr_pkg::coord_type start_y,
   input  lr_pkg::coord_type end_x,
   input  lr_pkg::coord_type end_y,
   input  lr_pkg::color_type line_color,
   output logic              push,
   output lr_pkg::entry_type entry,
   input  logic              queue_ready
);
   import lr_pkg::*;

   coord_type abs_dx;
   coord_type abs_dy;
   dir_type   dir_x;
   dir_type   dir_y;

   always_comb begin
      if (end_x > start_x) begin
         abs_dx = end_x - start_x;
         dir_x  = DIR_PLUS;
      end else if (end_x == start_x) begin
         abs_dx = '0;
         dir_x  = DIR_NONE;
      end else begin
         abs_dx = start_x - end_x;
         dir_x  = DIR_MINUS;
      end
      if (end_y > start_y) begin
         abs_dy = end_y - start_y;
         dir_y  = DIR_PLUS;
      end else if (end_y == start_y) begin
         abs_dy = '0;
         dir_y  = DIR_NONE;
      end else begin
         abs_dy = start_y - end_y;
         dir_y  = DIR_MINUS;
      end
   end

   always_comb begin
      entry.action    = action;
      entry.col       = start_x;
      entry.row       = start_y;
      entry.abs_dx    = abs_dx;
      entry.abs_dy    = abs_dy;
      entry.step_col  = dir_x;
      entry.step_row  = dir_y;
      entry.major_len = (abs_dx > abs_dy) ? abs_dx : abs_dy;
      entry.color     = line_color;
   end

   assign req_ready = queue_ready;
   assign push      = req_valid & queue_ready;

endmodule

[sv/lr_queue.sv]
// two-entry queue between the front end and the pixel stepper
// depends on lr_pkg
module lr_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  lr_pkg::entry_type push_entry,
   output logic              ready,
   input  logic              pop,
   output logic              valid,
   output lr_pkg::entry_type head
);
   import lr_pkg::*;

   entry_type              slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;

   assign ready = (count_ff != QUEUE_CNT_W'(QUEUE_DEPTH));
   assign valid = (count_ff != '0);
   assign head  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

[sv/lr_back.sv]
// pixel stepper: holds the line state, runs the error accumulators and
// drives the registered result beat; depends on lr_pkg
module lr_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  lr_pkg::entry_type q_head,
   output logic              q_pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output lr_pkg::pixel_type rsp_pixel
);
   import lr_pkg::*;

   logic      busy_ff, busy_in;
   coord_type cur_col_ff, cur_col_in;
   coord_type cur_row_ff, cur_row_in;
   coord_type abs_dx_ff, abs_dx_in;
   coord_type abs_dy_ff, abs_dy_in;
   coord_type major_ff, major_in;
   acc_type   err_col_ff, err_col_in;
   acc_type   err_row_ff, err_row_in;
   dir_type   step_col_ff, step_col_in;
   dir_type   step_row_ff, step_row_in;
   acc_type   remaining_ff, remaining_in;
   color_type color_ff, color_in;
   logic      rsp_valid_ff, rsp_valid_in;
   pixel_type rsp_pixel_ff, rsp_pixel_in;

   logic    out_free;
   logic    is_load;
   logic    emit;
   acc_type sum_col;
   acc_type sum_row;
   acc_type major_ext;

   function automatic coord_type move_axis(coord_type pos, dir_type dir);
      coord_type res;
      case (dir)
         DIR_PLUS:  res = pos + 1'b1;
         DIR_MINUS: res = pos - 1'b1;
         default:   res = pos;
      endcase
      return res;
   endfunction

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign is_load   = (q_head.action == ACT_LOAD);
   // a step while idle is dropped without touching the output
   assign q_pop     = q_valid && (is_load || !busy_ff || out_free);
   assign emit      = q_pop && !is_load && busy_ff;
   assign major_ext = {1'b0, major_ff};
   assign sum_col   = err_col_ff + {1'b0, abs_dx_ff};
   assign sum_row   = err_row_ff + {1'b0, abs_dy_ff};

   always_comb begin
      busy_in      = busy_ff;
      cur_col_in   = cur_col_ff;
      cur_row_in   = cur_row_ff;
      abs_dx_in    = abs_dx_ff;
      abs_dy_in    = abs_dy_ff;
      major_in     = major_ff;
      err_col_in   = err_col_ff;
      err_row_in   = err_row_ff;
      step_col_in  = step_col_ff;
      step_row_in  = step_row_ff;
      remaining_in = remaining_ff;
      color_in     = color_ff;
      if (q_pop && is_load) begin
         busy_in      = 1'b1;
         cur_col_in   = q_head.col;
         cur_row_in   = q_head.row;
         abs_dx_in    = q_head.abs_dx;
         abs_dy_in    = q_head.abs_dy;
         major_in     = q_head.major_len;
         err_col_in   = '0;
         err_row_in   = '0;
         step_col_in  = q_head.step_col;
         step_row_in  = q_head.step_row;
         remaining_in = {1'b0, q_head.major_len} + ACC_WIDTH'(2);
         color_in     = q_head.color;
      end else if (emit) begin
         remaining_in = remaining_ff - 1'b1;
         if (remaining_ff == ACC_WIDTH'(1)) begin
            busy_in = 1'b0;
         end
         if (sum_col > major_ext) begin
            err_col_in = sum_col - major_ext;
            cur_col_in = move_axis(cur_col_ff, step_col_ff);
         end else begin
            err_col_in = sum_col;
         end
         if (sum_row > major_ext) begin
            err_row_in = sum_row - major_ext;
            cur_row_in = move_axis(cur_row_ff, step_row_ff);
         end else begin
            err_row_in = sum_row;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_pixel_in = rsp_pixel_ff;
      if (emit) begin
         rsp_valid_in       = 1'b1;
         rsp_pixel_in.x     = cur_col_ff;
         rsp_pixel_in.y     = cur_row_ff;
         rsp_pixel_in.color = color_ff;
         rsp_pixel_in.last  = (remaining_ff == ACC_WIDTH'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_col_ff   <= cur_col_in;
      cur_row_ff   <= cur_row_in;
      abs_dx_ff    <= abs_dx_in;
      abs_dy_ff    <= abs_dy_in;
      major_ff     <= major_in;
      err_col_ff   <= err_col_in;
      err_row_ff   <= err_row_in;
      step_col_ff  <= step_col_in;
      step_row_ff  <= step_row_in;
      remaining_ff <= remaining_in;
      color_ff     <= color_in;
      rsp_pixel_ff <= rsp_pixel_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_pixel = rsp_pixel_ff;

endmodule

[sv/line_rasterizer.sv]
// line rasterizer top level: front end, item queue and pixel stepper
// depends on lr_pkg, lr_front, lr_queue, lr_back
//
//   channel   direction  carries
//   req_*     in         load (tuser 0) with endpoints and color, or step (tuser 1)
//   rsp_*     out        one pixel per emitting step, tlast on the line's final pixel
//
// one beat per cycle on each side while nothing stalls; a step beat is written into the
// queue, then popped by the stepper and registered as rsp_tvalid, after which it can leave
// the pace is set by the stepper, which handles one queue entry per cycle while its output is free
// reset (synchronous) empties the queue, drops any line and clears rsp_tvalid
// a stalled rsp holds the output register; the two-entry queue then fills
// and req_tready falls, so the front never waits on the back directly
module line_rasterizer (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // start_x, start_y, end_x, end_y, line_color, zero fill
   input  logic [lr_pkg::REQ_DATA_W-1:0] req_tdata,
   // action
   input  logic                          req_tuser,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // pixel_x, pixel_y, pixel_color, zero fill
   output logic [lr_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                          rsp_tlast
);
   import lr_pkg::*;

   localparam int SY = COORD_WIDTH;
   localparam int EX = 2 * COORD_WIDTH;
   localparam int EY = 3 * COORD_WIDTH;
   localparam int LC = 4 * COORD_WIDTH;

   logic      push;
   logic      q_ready;
   logic      q_valid;
   logic      q_pop;
   entry_type push_entry;
   entry_type q_head;
   pixel_type pixel;

   lr_front u_front (
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .action      (action_type'(req_tuser)),
      .start_x     (req_tdata[COORD_WIDTH-1:0]),
      .start_y     (req_tdata[SY +: COORD_WIDTH]),
      .end_x       (req_tdata[EX +: COORD_WIDTH]),
      .end_y       (req_tdata[EY +: COORD_WIDTH]),
      .line_color  (req_tdata[LC +: COLOR_WIDTH]),
      .push        (push),
      .entry       (push_entry),
      .queue_ready (q_ready)
   );

   lr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .ready      (q_ready),
      .pop        (q_pop),
      .valid      (q_valid),
      .head       (q_head)
   );

   lr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_pixel (pixel)
   );

   assign rsp_tdata = RSP_DATA_W'({pixel.color, pixel.y, pixel.x});
   assign rsp_tlast = pixel.last;

endmodule

[bench/tb_line_rasterizer.sv]
// self-checking bench for line_rasterizer: loads lines, steps them pixel by pixel
// and compares every rsp beat against a behavioral line tracer; needs lr_pkg
`timescale 1ns / 100ps

module tb_line_rasterizer;
   import lr_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_CYCLES = 60;
   localparam int COORD_MAX   = (1 << COORD_WIDTH) - 1;
   localparam coord_type COORD_TOP = coord_type'(COORD_MAX);

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;

   // line tracer state
   logic      line_active = 1'b0;
   coord_type pos_col = '0;
   coord_type pos_row = '0;
   coord_type delta_col = '0;
   coord_type delta_row = '0;
   coord_type span = '0;
   acc_type   acc_col = '0;
   acc_type   acc_row = '0;
   dir_type   dir_col = DIR_NONE;
   dir_type   dir_row = DIR_NONE;
   acc_type   pixels_left = '0;
   color_type line_color_q = '0;

   pixel_type pending_pixels[$];

   int error_count = 0;
   int loads_sent = 0;
   int steps_sent = 0;
   int items_sent = 0;
   int pixels_checked = 0;
   int input_held = 0;
   int cycle_count = 0;
   int send_idle_pct = 0;
   int rsp_idle_pct = 0;
   int stall_asked = 0;
   int stall_seen = 0;
   int stall_left = 0;

   line_rasterizer uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (!reset && req_tvalid && !req_tready) input_held++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d pixels outstanding", cycle_count,
                  pending_pixels.size());
         $display("FAILURE");
         $finish;
      end
   end

   function automatic coord_type axis_move(coord_type pos, dir_type dir);
      if (dir == DIR_PLUS) return pos + 1'b1;
      if (dir == DIR_MINUS) return pos - 1'b1;
      return pos;
   endfunction

   // advance the line tracer by one accepted beat, queueing the pixel it emits
   task automatic trace_beat(action_type act, coord_type sx, coord_type sy,
                             coord_type ex, coord_type ey, color_type c);
      pixel_type px;
      if (act == ACT_LOAD) begin
         if (ex > sx) begin
            delta_col = ex - sx;
            dir_col = DIR_PLUS;
         end else if (ex == sx) begin
            delta_col = '0;
            dir_col = DIR_NONE;
         end else begin
            delta_col = sx - ex;
            dir_col = DIR_MINUS;
         end
         if (ey > sy) begin
            delta_row = ey - sy;
            dir_row = DIR_PLUS;
         end else if (ey == sy) begin
            delta_row = '0;
            dir_row = DIR_NONE;
         end else begin
            delta_row = sy - ey;
            dir_row = DIR_MINUS;
         end
         span = (delta_col > delta_row) ? delta_col : delta_row;
         pos_col = sx;
         pos_row = sy;
         acc_col = '0;
         acc_row = '0;
         pixels_left = acc_type'(span) + acc_type'(2);
         line_color_q = c;
         line_active = 1'b1;
         loads_sent++;
      end else begin
         steps_sent++;
         if (line_active) begin
            pixels_left = pixels_left - 1'b1;
            px.x = pos_col;
            px.y = pos_row;
            px.color = line_color_q;
            px.last = (pixels_left == 0);
            pending_pixels.push_back(px);
            acc_col = acc_col + acc_type'(delta_col);
            acc_row = acc_row + acc_type'(delta_row);
            if (acc_col > acc_type'(span)) begin
               acc_col = acc_col - acc_type'(span);
               pos_col = axis_move(pos_col, dir_col);
            end
            if (acc_row > acc_type'(span)) begin
               acc_row = acc_row - acc_type'(span);
               pos_row = axis_move(pos_row, dir_row);
            end
            if (pixels_left == 0) line_active = 1'b0;
         end
      end
      items_sent++;
   endtask

   task automatic send_beat(action_type act, coord_type sx, coord_type sy,
                            coord_type ex, coord_type ey, color_type c);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= act;
      req_tdata <= REQ_DATA_W'({c, ey, ex, sy, sx});
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      trace_beat(act, sx, sy, ex, ey, c);
   endtask

   // step beats carry random, ignored endpoint fields
   task automatic send_step();
      send_beat(ACT_STEP, coord_type'($urandom), coord_type'($urandom),
                coord_type'($urandom), coord_type'($urandom), color_type'($urandom));
   endtask

   // stop offering beats until every queued pixel has come back
   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic coord_type near_coord(coord_type c, int reach);
      int lo;
      int hi;
      lo = (int'(c) > reach) ? int'(c) - reach : 0;
      hi = (int'(c) + reach < COORD_MAX) ? int'(c) + reach : COORD_MAX;
      return coord_type'($urandom_range(hi, lo));
   endfunction

   task automatic test_idle_steps();
      send_step();
      send_step();
   endtask

   task automatic test_zero_length();
      send_beat(ACT_LOAD, COORD_TOP, COORD_TOP, COORD_TOP, COORD_TOP, '0);
      repeat (3) send_step();   // the third finds the block idle again
   endtask

   task automatic test_extreme_lines();
      send_beat(ACT_LOAD, '0, '0, COORD_TOP, COORD_TOP, '1);
      repeat (3) send_step();
      // reload mid-line, opposite diagonal
      send_beat(ACT_LOAD, COORD_TOP, '0, '0, COORD_TOP, 16'h0000);
      repeat (2) send_step();
      send_beat(ACT_LOAD, 11'd5, 11'd9, 11'd8, 11'd3, 16'hA5A5);
      repeat (8) send_step();
   endtask

   // receiver freezes while steps keep coming, so the queue fills up
   task automatic test_backpressure();
      int saved_pct;
      saved_pct = send_idle_pct;
      send_idle_pct = 0;
      stall_asked++;
      send_beat(ACT_LOAD, 11'd100, 11'd200, 11'd112, 11'd195, color_type'($urandom));
      repeat (16) send_step();
      send_idle_pct = saved_pct;
      drain();
   endtask

   task automatic test_random_lines(int budget);
      int first_item;
      int pick;
      int reach;
      int cap;
      int n;
      coord_type sx;
      coord_type sy;
      first_item = items_sent;
      while (items_sent - first_item < budget) begin
         pick = $urandom_range(99);
         if (pick < 6) begin
            send_beat(action_type'($urandom_range(1)), coord_type'($urandom),
                      coord_type'($urandom), coord_type'($urandom),
                      coord_type'($urandom), color_type'($urandom));
         end else begin
            pick = $urandom_range(99);
            reach = (pick < 80) ? 12 : (pick < 95) ? 120 : COORD_MAX;
            sx = coord_type'($urandom);
            sy = coord_type'($urandom);
            send_beat(ACT_LOAD, sx, sy, near_coord(sx, reach), near_coord(sy, reach),
                      color_type'($urandom));
            // long lines and some short ones are cut off by the next load
            if (reach == COORD_MAX || $urandom_range(99) < 15) cap = $urandom_range(30);
            else cap = 1 << 30;
            n = 0;
            while (line_active && n < cap) begin
               send_step();
               n++;
            end
            if (!line_active && $urandom_range(99) < 20) send_step();
         end
      end
   endtask

   // result side: random or forced hold-off, and the pixel compare
   always @(posedge clock) begin
      pixel_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_pixels.size() == 0) begin
            $error("pixel beat with nothing expected: x %0d y %0d", rsp_tdata[COORD_WIDTH-1:0],
                   rsp_tdata[2*COORD_WIDTH-1:COORD_WIDTH]);
            error_count++;
         end else begin
            want = pending_pixels.pop_front();
            pixels_checked++;
            if (rsp_tdata[COORD_WIDTH-1:0] !== want.x) begin
               $error("pixel_x: expected %0d, got %0d", want.x, rsp_tdata[COORD_WIDTH-1:0]);
               error_count++;
            end
            if (rsp_tdata[2*COORD_WIDTH-1:COORD_WIDTH] !== want.y) begin
               $error("pixel_y: expected %0d, got %0d", want.y,
                      rsp_tdata[2*COORD_WIDTH-1:COORD_WIDTH]);
               error_count++;
            end
            if (rsp_tdata[2*COORD_WIDTH+COLOR_WIDTH-1:2*COORD_WIDTH] !== want.color) begin
               $error("pixel_color: expected %h, got %h", want.color,
                      rsp_tdata[2*COORD_WIDTH+COLOR_WIDTH-1:2*COORD_WIDTH]);
               error_count++;
            end
            if (rsp_tlast !== want.last) begin
               $error("last: expected %0d, got %0d", want.last, rsp_tlast);
               error_count++;
            end
         end
      end
      if (stall_seen != stall_asked) begin
         stall_seen = stall_asked;
         stall_left = HOLD_CYCLES;
      end
      if (stall_left != 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   initial begin
      int drain_wait;
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tuser <= ACT_LOAD;
      req_tdata <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 15;
      rsp_idle_pct = 69;
      test_idle_steps();
      test_zero_length();
      test_extreme_lines();
      test_random_lines(200);
      drain();

      send_idle_pct = 69;
      rsp_idle_pct = 15;
      test_random_lines(200);
      drain();

      send_idle_pct = 0;
      rsp_idle_pct = 0;
      test_backpressure();
      test_random_lines(200);

      req_tvalid <= 1'b0;
      drain_wait = 0;
      while (pending_pixels.size() != 0 && drain_wait < 5000) begin
         @(posedge clock);
         drain_wait++;
      end
      if (pending_pixels.size() != 0) begin
         $error("%0d expected pixels never arrived", pending_pixels.size());
         error_count++;
      end
      repeat (8) @(posedge clock);

      $display("drew %0d line loads and %0d step beats, %0d pixels compared",
               loads_sent, steps_sent, pixels_checked);
      $display("req held off on %0d cycles, including a %0d-cycle rsp freeze",
               input_held, HOLD_CYCLES);
      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
